// File: rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Holds the operation and status codes and the record passed from front to back.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam logic [2:0] FUNC_ADD = 3'd0;
    localparam logic [2:0] FUNC_SUB = 3'd1;
    localparam logic [2:0] FUNC_MUL = 3'd2;
    localparam logic [2:0] FUNC_DIV = 3'd3;
    localparam logic [2:0] FUNC_CMP = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_ZERO_DEN = 2'd3;

    // classified item sent from the front part to the back part
    typedef struct packed {
        logic        compute;   // back part must reduce a fraction
        logic        add_sub;   // numerator is a sum of two products
        logic        sub;       // second product is negated
        logic [2:0]  cmp;       // less, equal, greater
        logic [1:0]  status;
        logic [31:0] x1;        // numerator product operands
        logic [31:0] y1;
        logic [31:0] x2;        // second numerator product (add/sub)
        logic [31:0] y2;
        logic [31:0] dx;        // denominator product operands
        logic [31:0] dy;
        logic [31:0] echo_num;
        logic [31:0] echo_den;
    } t_item;

endpackage

// File: rtl/rau_front.sv
// ----------------------------------------------------------------------------
// rau_front: classifies an item and forms its operand set
// Decodes the operation, detects zero denominators, divide by zero and runs
// the compare, which needs the two cross products only.
// ----------------------------------------------------------------------------
module rau_front #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [2:0]          i_func,
    input  logic [VALUE_WIDTH-1:0] i_a_num,
    input  logic [VALUE_WIDTH-1:0] i_a_den,
    input  logic [VALUE_WIDTH-1:0] i_b_num,
    input  logic [VALUE_WIDTH-1:0] i_b_den,
    output logic                o_valid,
    input  logic                i_ready,
    output rau_pkg::t_item      o_item
);

    typedef enum logic [1:0] {S_IDLE, S_MUL1, S_MUL2, S_OUT} t_state;

    t_state r_state, n_state;
    rau_pkg::t_item r_item, n_item;
    logic signed [63:0] r_left, n_left, r_right, n_right;
    logic signed [31:0] an, ad, bn, bd;

    assign an = 32'(signed'(i_a_num));
    assign ad = 32'(signed'(i_a_den));
    assign bn = 32'(signed'(i_b_num));
    assign bd = 32'(signed'(i_b_den));

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_item  = r_item;

    always_comb begin
        logic zd;
        zd = (ad == 32'sd0) || (bd == 32'sd0);
        n_state = r_state;
        n_item  = r_item;
        n_left  = r_left;
        n_right = r_right;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_item = '0;
                    n_item.echo_num = 32'(an);
                    n_item.echo_den = 32'(ad);
                    n_item.x1 = 32'(an);
                    n_item.y1 = 32'(bd);
                    n_item.x2 = 32'(ad);
                    n_item.y2 = 32'(bn);
                    n_item.dx = 32'(ad);
                    n_item.dy = 32'(bd);
                    n_state = S_OUT;
                    case (i_func)
                        rau_pkg::FUNC_CMP: begin
                            n_item.status = zd ? rau_pkg::ST_ZERO_DEN : rau_pkg::ST_OK;
                            n_state = S_MUL1;
                        end
                        rau_pkg::FUNC_ADD, rau_pkg::FUNC_SUB: begin
                            if (zd) n_item.status = rau_pkg::ST_ZERO_DEN;
                            else begin
                                n_item.compute = 1'b1;
                                n_item.add_sub = 1'b1;
                                n_item.sub = (i_func == rau_pkg::FUNC_SUB);
                            end
                        end
                        rau_pkg::FUNC_MUL: begin
                            if (zd) n_item.status = rau_pkg::ST_ZERO_DEN;
                            else begin
                                n_item.compute = 1'b1;
                                n_item.y1 = 32'(bn);
                            end
                        end
                        rau_pkg::FUNC_DIV: begin
                            if (zd) n_item.status = rau_pkg::ST_ZERO_DEN;
                            else if (bn == 32'sd0) n_item.status = rau_pkg::ST_DIV_ZERO;
                            else begin
                                n_item.compute = 1'b1;
                                n_item.dy = 32'(bn);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL1: begin
                n_left  = 64'(signed'(n_item.x1)) * 64'(signed'(n_item.y1));
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_right = 64'(signed'(r_item.x2)) * 64'(signed'(r_item.y2));
                n_state = S_OUT;
                n_item.cmp = {(r_left < n_right), (r_left == n_right),
                              (r_left > n_right)};
            end
            S_OUT: begin
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_item  <= n_item;
        r_left  <= n_left;
        r_right <= n_right;
    end

endmodule

// File: rtl/rau_fifo.sv
// ----------------------------------------------------------------------------
// rau_fifo: two-entry queue between front and back
// Lets the front classify the next item while the back is busy.
// ----------------------------------------------------------------------------
module rau_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rau_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output rau_pkg::t_item o_item
);

    rau_pkg::t_item r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic wr, rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
        if (wr) r_mem[r_wp] <= i_item;
    end

endmodule

// File: rtl/rau_back.sv
// ----------------------------------------------------------------------------
// rau_back: exact product, Euclidean reduction and range check
// Forms the products one per cycle, runs a bit-serial gcd (remainder one
// bit a cycle) and divides both parts by the gcd bit-serially.
// ----------------------------------------------------------------------------
module rau_back #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rau_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [VALUE_WIDTH-1:0] o_res_num,
    output logic [VALUE_WIDTH-1:0] o_res_den,
    output logic           o_less,
    output logic           o_equal,
    output logic           o_greater,
    output logic [1:0]     o_status
);

    typedef enum logic [3:0] {
        S_IDLE, S_P1, S_P2, S_PD, S_SUM, S_GSTART, S_GREM, S_DSTART, S_DIV,
        S_CHECK, S_OUT
    } t_state;

    localparam logic [63:0] LIM = 64'd1 << (VALUE_WIDTH - 1);

    t_state r_state;
    rau_pkg::t_item r_item;
    logic [63:0] r_p1, r_p2, r_pd;   // magnitudes
    logic r_s1, r_s2, r_sd;
    logic [63:0] r_num, r_den, r_x, r_y, r_rem, r_q, r_dv, r_g;
    logic r_neg, r_sel;
    logic [6:0] r_bit;
    logic [31:0] r_on, r_od;
    logic [1:0] r_st;
    logic [64:0] sh, trial;

    // magnitude and sign of a 32-bit product
    function automatic logic [64:0] smul(input logic [31:0] x, input logic [31:0] y);
        logic [31:0] mx, my;
        logic [63:0] m;
        mx = x[31] ? (~x + 32'd1) : x;
        my = y[31] ? (~y + 32'd1) : y;
        m = 64'(mx) * 64'(my);
        return {(m != 64'd0) && (x[31] != y[31]), m};
    endfunction

    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = (r_state == S_OUT);
    assign o_res_num = VALUE_WIDTH'(r_on);
    assign o_res_den = VALUE_WIDTH'(r_od);
    assign o_less    = r_item.cmp[2];
    assign o_equal   = r_item.cmp[1];
    assign o_greater = r_item.cmp[0];
    assign o_status  = r_st;

    // restoring remainder/quotient step shared by gcd and division
    assign sh    = {r_rem, r_x[63]};
    assign trial = sh - {1'b0, r_dv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_item <= i_item;
                    r_on   <= i_item.echo_num;
                    r_od   <= i_item.echo_den;
                    r_st   <= i_item.status;
                    r_state <= i_item.compute ? S_P1 : S_OUT;
                end
                S_P1: begin
                    {r_s1, r_p1} <= smul(r_item.x1, r_item.y1);
                    r_state <= S_P2;
                end
                S_P2: begin
                    {r_s2, r_p2} <= smul(r_item.x2, r_item.y2);
                    r_state <= S_PD;
                end
                S_PD: begin
                    {r_sd, r_pd} <= smul(r_item.dx, r_item.dy);
                    if (r_item.sub && r_s2 == 1'b0 && r_p2 != 64'd0) r_s2 <= 1'b1;
                    else if (r_item.sub) r_s2 <= 1'b0;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    logic [63:0] m;
                    logic s;
                    if (!r_item.add_sub) begin
                        m = r_p1; s = r_s1;
                    end else if (r_s1 == r_s2) begin
                        m = r_p1 + r_p2; s = r_s1;
                    end else if (r_p1 >= r_p2) begin
                        m = r_p1 - r_p2; s = r_s1;
                    end else begin
                        m = r_p2 - r_p1; s = r_s2;
                    end
                    r_neg <= (m != 64'd0) && (s != r_sd);
                    r_g   <= m;     // gcd pair: (m, den)
                    r_y   <= r_pd;
                    if (m == 64'd0) begin
                        r_num <= 64'd0;
                        r_den <= 64'd1;
                        r_state <= S_CHECK;
                    end else begin
                        r_num <= m;
                        r_den <= r_pd;
                        r_state <= S_GSTART;
                    end
                end
                S_GSTART: begin
                    if (r_y == 64'd0) begin
                        r_sel <= 1'b0;
                        r_state <= S_DSTART;
                    end else begin
                        r_x   <= r_g;
                        r_dv  <= r_y;
                        r_rem <= 64'd0;
                        r_bit <= 7'd64;
                        r_state <= S_GREM;
                    end
                end
                S_GREM: begin
                    r_rem <= trial[64] ? sh[63:0] : trial[63:0];
                    r_x   <= {r_x[62:0], 1'b0};
                    r_bit <= r_bit - 7'd1;
                    if (r_bit == 7'd1) begin
                        r_g <= r_y;
                        r_y <= trial[64] ? sh[63:0] : trial[63:0];
                        r_state <= S_GSTART;
                    end
                end
                S_DSTART: begin
                    r_x   <= r_sel ? r_den : r_num;
                    r_dv  <= r_g;
                    r_rem <= 64'd0;
                    r_q   <= 64'd0;
                    r_bit <= 7'd64;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= trial[64] ? sh[63:0] : trial[63:0];
                    r_x   <= {r_x[62:0], 1'b0};
                    r_q   <= {r_q[62:0], ~trial[64]};
                    r_bit <= r_bit - 7'd1;
                    if (r_bit == 7'd1) begin
                        if (r_sel) begin
                            r_den <= {r_q[62:0], ~trial[64]};
                            r_state <= S_CHECK;
                        end else begin
                            r_num <= {r_q[62:0], ~trial[64]};
                            r_sel <= 1'b1;
                            r_state <= S_DSTART;
                        end
                    end
                end
                S_CHECK: begin
                    if (r_den > LIM - 64'd1 ||
                        r_num > (r_neg ? LIM : LIM - 64'd1)) begin
                        r_st <= rau_pkg::ST_OVERFLOW;
                    end else begin
                        r_on <= r_neg ? 32'(64'd0 - r_num) : r_num[31:0];
                        r_od <= r_den[31:0];
                    end
                    r_state <= S_OUT;
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: exact arithmetic on two signed fractions
// ----------------------------------------------------------------------------
// Input channel i_valid/o_ready carries func and the two fractions; output
// channel o_valid/i_ready carries the reduced result, compare flags, status.
// A front part classifies each item (compare, error cases, operand set) and
// queues it in a two-entry queue; a back part forms the exact products,
// reduces by a Euclidean gcd whose remainders are taken one bit a cycle,
// and divides both parts by the gcd one bit a cycle.
// An error case or an unused code passes the back part without computing,
// a compare is decided in the front part, and a zero result skips the gcd
// and the divisions; otherwise the time grows with the number of gcd
// remainder steps, so it depends on the operands.
// The back part's gcd and division loops set the throughput; the front may
// run ahead by three items, two in the queue and one in its output register.
// After reset both parts are idle and the queue is empty. A result waits
// in the back's output register while the receiver stalls; the queue and
// front keep accepting until full.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [2:0]             i_func,
    input  logic [VALUE_WIDTH-1:0] i_a_num,
    input  logic [VALUE_WIDTH-1:0] i_a_den,
    input  logic [VALUE_WIDTH-1:0] i_b_num,
    input  logic [VALUE_WIDTH-1:0] i_b_den,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [VALUE_WIDTH-1:0] o_res_num,
    output logic [VALUE_WIDTH-1:0] o_res_den,
    output logic                   o_less,
    output logic                   o_equal,
    output logic                   o_greater,
    output logic [1:0]             o_status
);

    rau_pkg::t_item f_item, q_item;
    logic f_valid, f_ready, q_valid, q_ready;

    rau_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_func, .i_a_num, .i_a_den, .i_b_num, .i_b_den,
        .o_valid(f_valid), .i_ready(f_ready), .o_item(f_item)
    );

    rau_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_item(f_item),
        .o_valid(q_valid), .i_ready(q_ready), .o_item(q_item)
    );

    rau_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_item(q_item),
        .o_valid, .i_ready, .o_res_num, .o_res_den,
        .o_less, .o_equal, .o_greater, .o_status
    );

`ifndef NO_ASSERTIONS
    a_flags_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($onehot0({o_less, o_equal, o_greater})))
        else $error("compare flags not exclusive");
    a_flags_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_less || o_equal || o_greater)) |->
        (o_status == rau_pkg::ST_OK || o_status == rau_pkg::ST_ZERO_DEN))
        else $error("compare flags with a computed status");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_res_num) && $stable(o_status)))
        else $error("result changed while stalled");
`endif

endmodule

// File: tb/tb_rational_arithmetic_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rational_arithmetic_unit: self-checking bench for the fraction unit
// Drives fraction pairs and operations through the valid/ready input, predicts
// the reduced result, compare flags and status, and checks every output
// transfer in order under random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_unit;

    localparam logic [2:0] FUNC_UNUSED_LO  = 3'd5;
    localparam logic [2:0] FUNC_UNUSED_MID = 3'd6;
    localparam logic [2:0] FUNC_UNUSED_HI  = 3'd7;
    localparam logic [31:0] MIN_VAL = 32'h8000_0000;
    localparam logic [31:0] MAX_VAL = 32'h7FFF_FFFF;
    localparam int STALL_LIMIT = 200000;

    typedef struct packed {
        logic [31:0] num;
        logic [31:0] den;
        logic        less;
        logic        equal;
        logic        greater;
        logic [1:0]  status;
    } t_fraction_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_func;
    logic [31:0] i_a_num;
    logic [31:0] i_a_den;
    logic [31:0] i_b_num;
    logic [31:0] i_b_den;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_res_num;
    logic [31:0] o_res_den;
    logic        o_less;
    logic        o_equal;
    logic        o_greater;
    logic [1:0]  o_status;

    t_fraction_result expected_results[$];
    int fail_cnt = 0;
    int sent_cnt = 0;
    int checked_cnt = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_request = 0;
    int idle_cycles = 0;

    rational_arithmetic_unit #(.VALUE_WIDTH(32)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_func(i_func), .i_a_num(i_a_num), .i_a_den(i_a_den),
        .i_b_num(i_b_num), .i_b_den(i_b_den), .o_valid(o_valid),
        .i_ready(i_ready), .o_res_num(o_res_num), .o_res_den(o_res_den),
        .o_less(o_less), .o_equal(o_equal), .o_greater(o_greater),
        .o_status(o_status)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // sign and magnitude of a signed 32-bit field
    function automatic logic [64:0] split_value(logic [31:0] v);
        logic [31:0] m;
        m = v[31] ? (32'd0 - v) : v;
        return {v[31], 32'd0, m};
    endfunction

    function automatic logic [64:0] mul_sm(logic [64:0] x, logic [64:0] y);
        logic [63:0] m;
        m = x[63:0] * y[63:0];
        return {(m != 64'd0) && (x[64] ^ y[64]), m};
    endfunction

    function automatic logic [64:0] add_sm(logic [64:0] x, logic [64:0] y);
        logic [64:0] r;
        if (x[64] == y[64]) r = {x[64], x[63:0] + y[63:0]};
        else if (x[63:0] >= y[63:0]) r = {x[64], x[63:0] - y[63:0]};
        else r = {y[64], y[63:0] - x[63:0]};
        if (r[63:0] == 64'd0) r[64] = 1'b0;
        return r;
    endfunction

    function automatic longint signed_of(logic [64:0] x);
        longint m;
        m = longint'(x[63:0]);
        return x[64] ? -m : m;
    endfunction

    function automatic t_fraction_result reduce_fraction(logic [2:0] func,
            logic [31:0] a_num, logic [31:0] a_den, logic [31:0] b_num,
            logic [31:0] b_den);
        t_fraction_result r;
        logic [64:0] an, ad, bn, bd, num, den, t;
        logic [63:0] g, x, y, rem, lim;
        logic neg;
        longint lhs, rhs;
        an = split_value(a_num);
        ad = split_value(a_den);
        bn = split_value(b_num);
        bd = split_value(b_den);
        r = '{num: a_num, den: a_den, less: 1'b0, equal: 1'b0, greater: 1'b0,
              status: rau_pkg::ST_OK};
        if (func == rau_pkg::FUNC_CMP) begin
            // raw cross products, denominators not sign-normalized
            lhs = signed_of(mul_sm(an, bd));
            rhs = signed_of(mul_sm(ad, bn));
            r.less = lhs < rhs;
            r.equal = lhs == rhs;
            r.greater = lhs > rhs;
            if (ad[63:0] == 0 || bd[63:0] == 0) r.status = rau_pkg::ST_ZERO_DEN;
        end else if (func <= rau_pkg::FUNC_DIV) begin
            if (ad[63:0] == 0 || bd[63:0] == 0) begin
                r.status = rau_pkg::ST_ZERO_DEN;
            end else if (func == rau_pkg::FUNC_DIV && bn[63:0] == 0) begin
                r.status = rau_pkg::ST_DIV_ZERO;
            end else begin
                if (func == rau_pkg::FUNC_ADD || func == rau_pkg::FUNC_SUB) begin
                    t = mul_sm(ad, bn);
                    if (func == rau_pkg::FUNC_SUB && t[63:0] != 0) t[64] = ~t[64];
                    num = add_sm(mul_sm(an, bd), t);
                    den = mul_sm(ad, bd);
                end else if (func == rau_pkg::FUNC_MUL) begin
                    num = mul_sm(an, bn);
                    den = mul_sm(ad, bd);
                end else begin
                    num = mul_sm(an, bd);
                    den = mul_sm(ad, bn);
                end
                if (num[63:0] == 0) begin
                    num[63:0] = 64'd0;
                    den[63:0] = 64'd1;
                    neg = 1'b0;
                end else begin
                    x = num[63:0];
                    y = den[63:0];
                    while (y != 0) begin
                        rem = x % y;
                        x = y;
                        y = rem;
                    end
                    g = x;
                    num[63:0] = num[63:0] / g;
                    den[63:0] = den[63:0] / g;
                    neg = num[64] ^ den[64];
                end
                lim = 64'd1 << 31;
                if (den[63:0] > lim - 1 || num[63:0] > (neg ? lim : lim - 1)) begin
                    r.status = rau_pkg::ST_OVERFLOW;
                end else begin
                    r.num = neg ? (32'd0 - num[31:0]) : num[31:0];
                    r.den = den[31:0];
                end
            end
        end
        return r;
    endfunction

    task automatic send_item(logic [2:0] func, logic [31:0] a_num,
            logic [31:0] a_den, logic [31:0] b_num, logic [31:0] b_den);
        // idle cycle by cycle before offering the item
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= func;
        i_a_num <= a_num;
        i_a_den <= a_den;
        i_b_num <= b_num;
        i_b_den <= b_den;
        expected_results.push_back(reduce_fraction(func, a_num, a_den, b_num, b_den));
        sent_cnt++;
        do @(negedge i_clk); while (!o_ready);
        @(posedge i_clk);
    endtask

    // mostly small values so the gcd loop stays short, some extremes and full range
    function automatic logic [31:0] pick_value(bit den);
        int sel;
        sel = $urandom_range(99);
        if (sel < 55) return 32'($signed($urandom_range(40)) - 20);
        if (sel < 65) return den ? 32'($urandom_range(1, 1000)) : 32'($urandom_range(2000));
        if (sel < 72) begin
            case ($urandom_range(3))
                0: return MIN_VAL;
                1: return MAX_VAL;
                2: return MIN_VAL + 1;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (sel < 80) return 32'($urandom_range(65535)) << $urandom_range(16);
        return $urandom;
    endfunction

    // output side: random stall, or a long hold-off on request
    always @(posedge i_clk) begin
        static int hold_left = 0;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_request > 0 && hold_left == 0) begin
            hold_left = hold_request;
            hold_request = 0;
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // outputs are stable at the falling edge; a transfer happens at the next rising edge
    always @(negedge i_clk) begin
        t_fraction_result exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected: num %0d den %0d",
                       $signed(o_res_num), $signed(o_res_den));
                fail_cnt++;
            end else begin
                exp_res = expected_results.pop_front();
                checked_cnt++;
                if (o_res_num !== exp_res.num) begin
                    $error("res_num expected %0d actual %0d", $signed(exp_res.num),
                           $signed(o_res_num));
                    fail_cnt++;
                end
                if (o_res_den !== exp_res.den) begin
                    $error("res_den expected %0d actual %0d", $signed(exp_res.den),
                           $signed(o_res_den));
                    fail_cnt++;
                end
                if (o_less !== exp_res.less) begin
                    $error("less expected %0b actual %0b", exp_res.less, o_less);
                    fail_cnt++;
                end
                if (o_equal !== exp_res.equal) begin
                    $error("equal expected %0b actual %0b", exp_res.equal, o_equal);
                    fail_cnt++;
                end
                if (o_greater !== exp_res.greater) begin
                    $error("greater expected %0b actual %0b", exp_res.greater, o_greater);
                    fail_cnt++;
                end
                if (o_status !== exp_res.status) begin
                    $error("status expected %0d actual %0d", exp_res.status, o_status);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_rational_arithmetic_unit failed");
            $finish;
        end
    end

    task automatic test_directed();
        send_item(rau_pkg::FUNC_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        send_item(rau_pkg::FUNC_SUB, 32'd3, 32'd4, 32'd6, 32'd8);
        send_item(rau_pkg::FUNC_SUB, -32'sd1, 32'd2, 32'd1, -32'sd2);
        send_item(rau_pkg::FUNC_MUL, 32'd6, -32'sd4, -32'sd2, 32'd9);
        send_item(rau_pkg::FUNC_DIV, 32'd5, 32'd7, -32'sd10, 32'd3);
        send_item(rau_pkg::FUNC_DIV, 32'd5, 32'd7, 32'd0, 32'd3);
        send_item(rau_pkg::FUNC_ADD, 32'd1, 32'd0, 32'd1, 32'd2);
        send_item(rau_pkg::FUNC_CMP, 32'd1, 32'd0, 32'd1, 32'd2);
        send_item(rau_pkg::FUNC_DIV, 32'd1, 32'd2, 32'd0, 32'd0);
        send_item(rau_pkg::FUNC_CMP, 32'd1, -32'sd2, 32'd1, 32'd2);
        send_item(rau_pkg::FUNC_CMP, 32'd2, 32'd4, 32'd1, 32'd2);
        send_item(rau_pkg::FUNC_CMP, MIN_VAL, 32'd1, MAX_VAL, 32'd1);
        send_item(rau_pkg::FUNC_MUL, MIN_VAL, 32'd1, -32'sd1, 32'd1);
        send_item(rau_pkg::FUNC_DIV, MIN_VAL, 32'd1, 32'd1, 32'd1);
        send_item(rau_pkg::FUNC_DIV, 32'd1, MIN_VAL, 32'd1, 32'd1);
        send_item(rau_pkg::FUNC_DIV, 32'd1, MIN_VAL, -32'sd1, 32'd1);
        send_item(rau_pkg::FUNC_ADD, MAX_VAL, 32'd1, MAX_VAL, 32'd1);
        send_item(rau_pkg::FUNC_SUB, MIN_VAL, MIN_VAL, MAX_VAL, MAX_VAL);
        send_item(rau_pkg::FUNC_MUL, MAX_VAL, MIN_VAL, MIN_VAL, MAX_VAL);
        send_item(rau_pkg::FUNC_MUL, 32'd0, -32'sd5, 32'd3, 32'd7);
        send_item(FUNC_UNUSED_LO, 32'd3, 32'd0, 32'd1, 32'd2);
        send_item(FUNC_UNUSED_MID, MIN_VAL, MAX_VAL, 32'd1, 32'd1);
        send_item(FUNC_UNUSED_HI, 32'hFFFF_FFFF, 32'd0, MIN_VAL, 32'd0);
    endtask

    task automatic test_random(int n, int tx_pct, int rx_pct);
        logic [2:0] func;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (n) begin
            func = ($urandom_range(19) == 0)
                 ? 3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI))
                 : 3'($urandom_range(rau_pkg::FUNC_CMP));
            send_item(func, pick_value(0), pick_value(1), pick_value(0), pick_value(1));
        end
    endtask

    // long output hold-off while items keep coming, so the input stalls
    task automatic test_backpressure();
        tx_idle_pct = 0;
        hold_request = 600;
        repeat (10) send_item(3'($urandom_range(rau_pkg::FUNC_CMP)),
                              32'($signed($urandom_range(40)) - 20),
                              32'($urandom_range(1, 30)), 32'($signed($urandom_range(40)) - 20),
                              32'($urandom_range(1, 30)));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = rau_pkg::FUNC_ADD;
        i_a_num = '0;
        i_a_den = '0;
        i_b_num = '0;
        i_b_den = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(310, 23, 55);
        test_random(310, 55, 23);
        test_backpressure();
        test_random(300, 0, 0);
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("sent %0d items (all operations, zero denominators, extremes), checked %0d",
                 sent_cnt, checked_cnt);
        $display("idling on both sides, a long output stall, and back-to-back traffic");
        if (fail_cnt == 0) $display("tb_rational_arithmetic_unit passed");
        else $display("tb_rational_arithmetic_unit failed");
        $finish;
    end

endmodule
